FILE: hw/rtl/arp_pkg.sv
package arp_pkg;

   localparam logic [7:0]  SEMITONES = 8'd12;
   localparam logic [7:0]  TOP_NOTE  = 8'd127;
   localparam logic [15:0] LFSR_MASK = 16'hB400;

   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_TICK     = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PAT_UP     = 2'd0,
      PAT_DOWN   = 2'd1,
      PAT_UPDOWN = 2'd2,
      PAT_RANDOM = 2'd3
   } pattern_type;

   typedef enum logic [1:0] {
      CSR_ENABLE  = 2'd0,
      CSR_PATTERN = 2'd1,
      CSR_OCTAVES = 2'd2,
      CSR_SEED    = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADD,
      ST_OFF_MOVE,
      ST_REBUILD,
      ST_SORT,
      ST_EXPAND,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_UD_RD,
      ST_UD_WR,
      ST_SH_LFSR,
      ST_SH_DIV,
      ST_SH_RD_TOP,
      ST_SH_RD_PICK,
      ST_SH_WR_TOP,
      ST_SH_WR_PICK,
      ST_FINISH,
      ST_TICK_RD,
      ST_TICK_OUT
   } state_type;

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] note;
   } req_type;

   typedef struct packed {
      logic       has_note;
      logic [6:0] note_out;
   } rsp_type;

   function automatic logic [15:0] lfsr_step(input logic [15:0] s);
      logic [15:0] n;
      n = {1'b0, s[15:1]};
      if (s[0]) n = n ^ LFSR_MASK;
      return n;
   endfunction

endpackage

FILE: hw/rtl/arp_remainder.sv
module arp_remainder import arp_pkg::*; #(
   parameter int DIV_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [15:0]      dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] remainder
);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [15:0]      dv_ff, dv_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;

   // one restoring step per cycle, msb first
   always_comb begin
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dv_ff[15]};
      if (start) begin
         rem_in  = '0;
         dv_in   = dividend;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) trial = trial - {1'b0, divisor};
         rem_in = trial[DIV_W-1:0];
         dv_in  = {dv_ff[14:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/note_arpeggiator_top.sv
// Arpeggiator over a table of held notes. Drive start with an item while busy
// is low; a tick answers with one rsp_valid pulse that cannot be held off, so
// the receiver must take it in that cycle. Other ops give no result. A tick
// with no note answers from idle; one with a note first reads the sequence memory.
// A note on or off scans the held table (one entry per cycle), then, if the
// table changed, rebuilds: a selection sort over the held notes, octave
// expansion into the base table, a read and a write per sequence entry for
// the copy, and in random mode a shuffle that for each entry steps the LFSR,
// waits on the remainder unit, then reads and writes back two entries. A tick
// that wraps in random mode reshuffles the same way. busy stays high for all of it.
module note_arpeggiator_top import arp_pkg::*; #(
   parameter int HELD_DEPTH = 16,
   parameter int BASE_DEPTH = 64,
   parameter int SEQ_DEPTH  = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int HIW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
   localparam int HCW = $clog2(HELD_DEPTH + 1);
   localparam int BAW = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
   localparam int BCW = $clog2(BASE_DEPTH + 1);
   localparam int SAW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam int LW  = $clog2(SEQ_DEPTH + 1);

   // configuration
   logic        enable_ff;
   logic [1:0]  pattern_ff;
   logic [2:0]  octaves_ff;
   logic [15:0] seed_ff;

   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [6:0]  note_ff, note_in;
   logic [HCW-1:0] cnt_ff, cnt_in;
   logic [HCW-1:0] j_ff, j_in;
   logic [HCW-1:0] k_ff, k_in;
   logic [HIW-1:0] fidx_ff, fidx_in;
   logic [7:0]  prev_ff, prev_in;
   logic [7:0]  best_ff, best_in;
   logic [2:0]  oct_ff, oct_in;
   logic [7:0]  off_ff, off_in;
   logic [BCW-1:0] bc_ff, bc_in;
   logic [BCW-1:0] c_ff, c_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  s_ff, s_in;
   logic [SAW-1:0] idx_ff, idx_in;
   logic [SAW-1:0] pick_ff, pick_in;
   logic [6:0]  tmp_ff, tmp_in;
   logic [15:0] rng_ff, rng_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [6:0]  held_ff [HELD_DEPTH];
   logic [6:0]  sorted_ff [HELD_DEPTH];
   logic        held_we, sorted_we;
   logic [HIW-1:0] held_waddr, sorted_waddr, held_raddr;
   logic [6:0]  held_wdata, sorted_wdata, held_rd;

   logic [6:0]  base_mem [BASE_DEPTH];
   logic        base_we;
   logic [BAW-1:0] base_waddr, base_raddr;
   logic [6:0]  base_wdata, base_q_ff;

   logic [6:0]  seq_mem [SEQ_DEPTH];
   logic        seq_we;
   logic [SAW-1:0] seq_waddr, seq_raddr;
   logic [6:0]  seq_wdata, seq_q_ff;

   logic        div_start, div_done;
   logic [15:0] div_dividend;
   logic [LW-1:0] div_rem;

   logic [HCW-1:0] cnt_m1;
   logic [7:0]  cand, best_nx, expand_t;
   logic [LW-1:0] idx_nx;
   logic [BCW-1:0] down_addr;

   arp_remainder #(.DIV_W(LW)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (s_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign cnt_m1       = cnt_ff - 1'b1;
   assign held_raddr   = (state_ff == ST_OFF_MOVE) ? cnt_m1[HIW-1:0] : j_ff[HIW-1:0];
   assign held_rd      = held_ff[held_raddr];
   assign cand         = {1'b0, held_rd};
   assign best_nx      = (cand >= prev_ff && cand < best_ff) ? cand : best_ff;
   assign expand_t     = {1'b0, sorted_ff[j_ff[HIW-1:0]]} + off_ff;
   assign idx_nx       = LW'(idx_ff) + 1'b1;
   assign down_addr    = bc_ff - 1'b1 - c_ff;
   assign div_dividend = lfsr_step(rng_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      note_in      = note_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      fidx_in      = fidx_ff;
      prev_in      = prev_ff;
      best_in      = best_ff;
      oct_in       = oct_ff;
      off_in       = off_ff;
      bc_in        = bc_ff;
      c_in         = c_ff;
      len_in       = len_ff;
      s_in         = s_ff;
      idx_in       = idx_ff;
      pick_in      = pick_ff;
      tmp_in       = tmp_ff;
      rng_in       = rng_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      held_we      = 1'b0;
      held_waddr   = cnt_ff[HIW-1:0];
      held_wdata   = note_ff;
      sorted_we    = 1'b0;
      sorted_waddr = k_ff[HIW-1:0];
      sorted_wdata = best_nx[6:0];
      base_we      = 1'b0;
      base_waddr   = bc_ff[BAW-1:0];
      base_wdata   = expand_t[6:0];
      base_raddr   = c_ff[BAW-1:0];
      seq_we       = 1'b0;
      seq_waddr    = len_ff[SAW-1:0];
      seq_wdata    = base_q_ff;
      seq_raddr    = idx_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req_payload.op;
               note_in = req_payload.note;
               j_in    = '0;
               unique case (op_type'(req_payload.op))
                  OP_NOTE_ON: begin
                     state_in = (cnt_ff == '0) ? ST_ADD : ST_SCAN;
                  end
                  OP_NOTE_OFF: begin
                     if (cnt_ff != '0) state_in = ST_SCAN;
                  end
                  OP_TICK: begin
                     if (enable_ff && len_ff != '0 && LW'(idx_ff) < len_ff) begin
                        state_in = ST_TICK_RD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                     len_in = '0;
                     idx_in = '0;
                     rng_in = (seed_ff == '0) ? 16'd1 : seed_ff;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (held_rd == note_ff) begin
               if (op_ff == OP_NOTE_ON) begin
                  state_in = ST_IDLE;
               end else begin
                  fidx_in  = j_ff[HIW-1:0];
                  state_in = ST_OFF_MOVE;
               end
            end else if (j_ff == cnt_m1) begin
               state_in = (op_ff == OP_NOTE_ON) ? ST_ADD : ST_IDLE;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_ADD: begin
            if (cnt_ff < HCW'(HELD_DEPTH)) begin
               held_we  = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_REBUILD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OFF_MOVE: begin
            // last entry fills the freed slot
            held_we    = 1'b1;
            held_waddr = fidx_ff;
            held_wdata = held_rd;
            cnt_in     = cnt_m1;
            state_in   = ST_REBUILD;
         end
         ST_REBUILD: begin
            len_in   = '0;
            j_in     = '0;
            k_in     = '0;
            prev_in  = '0;
            best_in  = 8'd128;
            bc_in    = '0;
            c_in     = '0;
            oct_in   = '0;
            off_in   = '0;
            state_in = (cnt_ff == '0) ? ST_FINISH : ST_SORT;
         end
         ST_SORT: begin
            // each pass picks the smallest note at or above the threshold
            if (j_ff == cnt_m1) begin
               sorted_we = 1'b1;
               prev_in   = best_nx + 8'd1;
               best_in   = 8'd128;
               j_in      = '0;
               if (k_ff == cnt_m1) begin
                  state_in = (octaves_ff == '0) ? ST_COPY_RD : ST_EXPAND;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               best_in = best_nx;
               j_in    = j_ff + 1'b1;
            end
         end
         ST_EXPAND: begin
            if (expand_t <= TOP_NOTE && bc_ff < BCW'(BASE_DEPTH)) begin
               base_we = 1'b1;
               bc_in   = bc_ff + 1'b1;
            end
            if (j_ff == cnt_m1) begin
               j_in   = '0;
               oct_in = oct_ff + 3'd1;
               off_in = off_ff + SEMITONES;
               if (oct_ff == octaves_ff - 3'd1) state_in = ST_COPY_RD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_COPY_RD: begin
            if (c_ff < bc_ff && len_ff < LW'(SEQ_DEPTH)) begin
               if (pattern_ff == PAT_DOWN) base_raddr = down_addr[BAW-1:0];
               state_in = ST_COPY_WR;
            end else if (pattern_ff == PAT_UPDOWN && bc_ff > BCW'(1)) begin
               c_in     = bc_ff - BCW'(2);
               state_in = ST_UD_RD;
            end else if (pattern_ff == PAT_RANDOM && len_ff > LW'(1)) begin
               s_in     = len_ff;
               state_in = ST_SH_LFSR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_COPY_WR: begin
            seq_we   = 1'b1;
            len_in   = len_ff + 1'b1;
            c_in     = c_ff + 1'b1;
            state_in = ST_COPY_RD;
         end
         ST_UD_RD: begin
            if (c_ff == '0 || len_ff >= LW'(SEQ_DEPTH)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_UD_WR;
            end
         end
         ST_UD_WR: begin
            seq_we   = 1'b1;
            len_in   = len_ff + 1'b1;
            c_in     = c_ff - 1'b1;
            state_in = ST_UD_RD;
         end
         ST_SH_LFSR: begin
            rng_in    = div_dividend;
            div_start = 1'b1;
            state_in  = ST_SH_DIV;
         end
         ST_SH_DIV: begin
            if (div_done) begin
               pick_in  = div_rem[SAW-1:0];
               state_in = ST_SH_RD_TOP;
            end
         end
         ST_SH_RD_TOP: begin
            seq_raddr = SAW'(s_ff - 1'b1);
            state_in  = ST_SH_RD_PICK;
         end
         ST_SH_RD_PICK: begin
            tmp_in    = seq_q_ff;
            seq_raddr = pick_ff;
            state_in  = ST_SH_WR_TOP;
         end
         ST_SH_WR_TOP: begin
            seq_we    = 1'b1;
            seq_waddr = SAW'(s_ff - 1'b1);
            seq_wdata = seq_q_ff;
            state_in  = ST_SH_WR_PICK;
         end
         ST_SH_WR_PICK: begin
            seq_we    = 1'b1;
            seq_waddr = pick_ff;
            seq_wdata = tmp_ff;
            s_in      = s_ff - 1'b1;
            state_in  = (s_ff > LW'(2)) ? ST_SH_LFSR : ST_FINISH;
         end
         ST_FINISH: begin
            if (LW'(idx_ff) >= len_ff) idx_in = '0;
            state_in = ST_IDLE;
         end
         ST_TICK_RD: begin
            state_in = ST_TICK_OUT;
         end
         ST_TICK_OUT: begin
            rsp_valid_in     = 1'b1;
            rsp_in.has_note  = 1'b1;
            rsp_in.note_out  = seq_q_ff;
            state_in         = ST_IDLE;
            if (idx_nx == len_ff) begin
               idx_in = '0;
               // wrap in random mode reshuffles
               if (pattern_ff == PAT_RANDOM && len_ff > LW'(1)) begin
                  s_in     = len_ff;
                  state_in = ST_SH_LFSR;
               end
            end else begin
               idx_in = idx_nx[SAW-1:0];
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         pattern_ff   <= PAT_UP;
         octaves_ff   <= 3'd1;
         seed_ff      <= 16'd1;
         cnt_ff       <= '0;
         len_ff       <= '0;
         idx_ff       <= '0;
         rng_ff       <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         rng_ff       <= rng_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_ENABLE:  enable_ff  <= csr_wdata[0];
               CSR_PATTERN: pattern_ff <= csr_wdata[1:0];
               CSR_OCTAVES: octaves_ff <= csr_wdata[2:0];
               CSR_SEED:    seed_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
      op_ff   <= op_in;
      note_ff <= note_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      fidx_ff <= fidx_in;
      prev_ff <= prev_in;
      best_ff <= best_in;
      oct_ff  <= oct_in;
      off_ff  <= off_in;
      bc_ff   <= bc_in;
      c_ff    <= c_in;
      s_ff    <= s_in;
      pick_ff <= pick_in;
      tmp_ff  <= tmp_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (held_we) held_ff[held_waddr] <= held_wdata;
      if (sorted_we) sorted_ff[sorted_waddr] <= sorted_wdata;
   end

   always_ff @(posedge clock) begin
      if (base_we) base_mem[base_waddr] <= base_wdata;
      base_q_ff <= base_mem[base_raddr];
   end

   always_ff @(posedge clock) begin
      if (seq_we) seq_mem[seq_waddr] <= seq_wdata;
      seq_q_ff <= seq_mem[seq_raddr];
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: sim/note_arpeggiator_top_tb.sv
module note_arpeggiator_top_tb;
   import arp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HELD_MAX   = 16;
   localparam int BASE_MAX   = 64;
   localparam int SEQ_MAX    = 128;
   localparam int CYCLE_CAP  = 20000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   note_arpeggiator_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   req_type item_q[$];
   rsp_type note_exp_q[$];
   int      n_issued = 0;
   int      n_taken = 0;
   int      errors = 0;
   int      cycles = 0;
   bit      no_idle = 1'b0;

   // arpeggiator shadow state
   bit          arp_en;
   pattern_type arp_pat;
   bit [2:0]    arp_oct;
   bit [15:0]   arp_seed;
   bit [6:0]    held_tab[HELD_MAX];
   int          held_n;
   bit [6:0]    play_seq[SEQ_MAX];
   int          play_len;
   int          play_pos;
   bit [15:0]   shuf_lfsr;

   function automatic void shuffle_play_seq();
      bit [6:0] tmp;
      int pick;
      for (int i = play_len; i > 1; i--) begin
         shuf_lfsr = {1'b0, shuf_lfsr[15:1]} ^ (shuf_lfsr[0] ? 16'hB400 : 16'h0000);
         pick = int'(shuf_lfsr) % i;
         tmp = play_seq[i-1];
         play_seq[i-1] = play_seq[pick];
         play_seq[pick] = tmp;
      end
   endfunction

   function automatic void rebuild_play_seq();
      bit [6:0] sorted[HELD_MAX];
      bit [6:0] base[BASE_MAX];
      int bc;
      int j;
      int t;
      int n;
      bc = 0;
      play_len = 0;
      if (held_n != 0) begin
         for (int i = 0; i < held_n; i++) begin
            j = i;
            while (j > 0 && sorted[j-1] > held_tab[i]) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = held_tab[i];
         end
         for (int o = 0; o < int'(arp_oct); o++)
            for (int i = 0; i < held_n; i++) begin
               t = int'(sorted[i]) + o * 12;
               if (t <= 127 && bc < BASE_MAX) begin
                  base[bc] = t[6:0];
                  bc++;
               end
            end
         n = bc < SEQ_MAX ? bc : SEQ_MAX;
         for (int i = 0; i < n; i++)
            play_seq[i] = (arp_pat == PAT_DOWN) ? base[bc-1-i] : base[i];
         play_len = n;
         if (arp_pat == PAT_UPDOWN && bc > 1) begin
            for (int i = bc - 2; i > 0; i--)
               if (play_len < SEQ_MAX) begin
                  play_seq[play_len] = base[i];
                  play_len++;
               end
         end else if (arp_pat == PAT_RANDOM) begin
            shuffle_play_seq();
         end
      end
      if (play_pos >= play_len) play_pos = 0;
   endfunction

   function automatic void apply_note_event(req_type it);
      int hit;
      rsp_type r;
      hit = -1;
      for (int i = 0; i < held_n; i++)
         if (held_tab[i] == it.note && hit < 0) hit = i;
      case (op_type'(it.op))
         OP_NOTE_ON: begin
            if (hit < 0 && held_n < HELD_MAX) begin
               held_tab[held_n] = it.note;
               held_n++;
               rebuild_play_seq();
            end
         end
         OP_NOTE_OFF: begin
            if (hit >= 0) begin
               held_n--;
               held_tab[hit] = held_tab[held_n];
               rebuild_play_seq();
            end
         end
         OP_CLEAR: begin
            held_n = 0;
            play_len = 0;
            play_pos = 0;
            shuf_lfsr = (arp_seed != 0) ? arp_seed : 16'd1;
         end
         default: begin
            r = '0;
            if (arp_en && play_len != 0 && play_pos < play_len) begin
               r.has_note = 1'b1;
               r.note_out = play_seq[play_pos];
               play_pos = (play_pos + 1) % play_len;
               if (arp_pat == PAT_RANDOM && play_pos == 0) shuffle_play_seq();
            end
            note_exp_q.push_back(r);
         end
      endcase
   endfunction

   // result check first, then record the transfer taken at this edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end else if (!reset) begin
         if (rsp_valid) begin
            if (note_exp_q.size() == 0) begin
               $display("%0t: unexpected result has_note=%0b note_out=%0d", $time,
                        rsp_payload.has_note, rsp_payload.note_out);
               errors++;
            end else begin
               rsp_type e;
               e = note_exp_q.pop_front();
               if (e.has_note !== rsp_payload.has_note)
                  begin
                     $display("%0t: has_note expected %0b actual %0b", $time,
                              e.has_note, rsp_payload.has_note);
                     errors++;
                  end
               if (e.note_out !== rsp_payload.note_out)
                  begin
                     $display("%0t: note_out expected %0d actual %0d", $time,
                              e.note_out, rsp_payload.note_out);
                     errors++;
                  end
            end
         end
         if (start && !busy) begin
            apply_note_event(req_payload);
            n_taken <= n_taken + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && !(start && n_taken != n_issued)) begin
         if (item_q.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
            req_payload <= item_q.pop_front();
            start <= 1'b1;
            n_issued <= n_issued + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic write_csr(csr_index_type idx, bit [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ENABLE:  arp_en = val[0];
         CSR_PATTERN: arp_pat = pattern_type'(val[1:0]);
         CSR_OCTAVES: arp_oct = val[2:0];
         default:     arp_seed = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic setup_phase(bit en, pattern_type pat, bit [2:0] oct, bit [15:0] seed);
      write_csr(CSR_ENABLE, {15'd0, en});
      write_csr(CSR_PATTERN, {14'd0, pat});
      write_csr(CSR_OCTAVES, {13'd0, oct});
      write_csr(CSR_SEED, seed);
   endtask

   task automatic add_item(op_type op, int note);
      req_type it;
      it.op = op;
      it.note = note[6:0];
      item_q.push_back(it);
   endtask

   // idle once every transfer is done and busy has stayed low a while
   task automatic drain();
      int quiet;
      quiet = 0;
      while (quiet < 8) begin
         @(negedge clock);
         if (item_q.size() == 0 && !start && note_exp_q.size() == 0 && !busy) quiet++;
         else quiet = 0;
      end
   endtask

   task automatic add_random_items(int count);
      int pool_lo;
      int r;
      pool_lo = $urandom_range(127 - 23);
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 3) add_item(OP_CLEAR, $urandom_range(127));
         else if (r < 38)
            add_item(OP_NOTE_ON, ($urandom_range(1) == 1) ? pool_lo + $urandom_range(23)
                                                          : $urandom_range(127));
         else if (r < 60)
            add_item(OP_NOTE_OFF, ($urandom_range(3) != 0) ? pool_lo + $urandom_range(23)
                                                           : $urandom_range(127));
         else add_item(OP_TICK, $urandom_range(127));
      end
   endtask

   initial begin
      arp_en = 1'b0;
      arp_pat = PAT_UP;
      arp_oct = 3'd1;
      arp_seed = 16'd1;
      held_n = 0;
      play_len = 0;
      play_pos = 0;
      shuf_lfsr = 16'd1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicates, unheld off, clear, empty tick
      setup_phase(1'b1, PAT_UPDOWN, 3'd4, 16'hFFFF);
      add_item(OP_TICK, 0);
      add_item(OP_NOTE_ON, 0);
      add_item(OP_NOTE_ON, 127);
      add_item(OP_NOTE_ON, 120);
      add_item(OP_NOTE_ON, 60);
      add_item(OP_NOTE_ON, 60);
      for (int k = 0; k < 8; k++) add_item(OP_TICK, 127);
      add_item(OP_NOTE_OFF, 127);
      add_item(OP_NOTE_OFF, 5);
      add_item(OP_TICK, 0);
      add_item(OP_CLEAR, 85);
      add_item(OP_TICK, 0);
      add_item(OP_NOTE_ON, 42);
      add_item(OP_TICK, 0);
      add_item(OP_TICK, 0);
      drain();
      setup_phase(1'b0, PAT_RANDOM, 3'd0, 16'd0);
      add_item(OP_CLEAR, 0);
      add_item(OP_NOTE_ON, 10);
      add_item(OP_TICK, 0);
      drain();

      setup_phase(1'b1, PAT_UP, 3'd1, 16'd1);
      add_random_items(180);
      drain();
      setup_phase(1'b1, PAT_DOWN, 3'd4, 16'hFFFF);
      add_random_items(180);
      drain();
      setup_phase(1'b1, PAT_RANDOM, 3'd2, 16'd0);
      add_item(OP_CLEAR, 0);
      no_idle = 1'b1;
      add_random_items(180);
      drain();
      no_idle = 1'b0;
      setup_phase(1'b1, PAT_UPDOWN, 3'd3, 16'h1234);
      add_random_items(180);
      drain();
      setup_phase(1'b1, PAT_RANDOM, 3'd4, 16'hACE1);
      add_item(OP_CLEAR, 0);
      add_random_items(180);
      drain();
      setup_phase(1'b0, PAT_UP, 3'd7, 16'h8001);
      add_random_items(60);
      drain();
      setup_phase(1'b1, PAT_RANDOM, 3'd1, 16'h0001);
      add_random_items(160);
      drain();

      repeat (50) @(negedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
